// ----- rtl/brb_pkg.sv -----
// ----------------------------------------------------------------------------
// brb_pkg
// Shared widths, command codes and the result record of the byte ring buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package brb_pkg;

  localparam int DEPTH_DEFAULT     = 4096;
  localparam int MAX_FETCH_DEFAULT = 64;
  localparam int RING_SIZE_RESET   = 4096;

  localparam int CMD_W    = 2;
  localparam int AMOUNT_W = 13;
  localparam int BYTE_W   = 8;
  localparam int FILL_W   = 12;
  localparam int CFG_W    = 13;

  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_TUSER_W = 2;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FETCH  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MARK   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd3;

  typedef struct packed {
    logic              accepted;
    logic              data_valid;
    logic [BYTE_W-1:0] data_byte;
    logic              last;
    logic [FILL_W-1:0] fill_count;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/brb_mem.sv -----
// ----------------------------------------------------------------------------
// brb_mem
// Byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module brb_mem #(
  parameter int DEPTH = brb_pkg::DEPTH_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr,
  input  wire logic [brb_pkg::BYTE_W-1:0] wdata,
  input  wire logic                       re,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr,
  output logic      [brb_pkg::BYTE_W-1:0] rdata
);

  logic [brb_pkg::BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/brb_ctrl.sv -----
// ----------------------------------------------------------------------------
// brb_ctrl
// Positions, fill, chunk admission, fetch sequencer and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module brb_ctrl #(
  parameter int DEPTH     = brb_pkg::DEPTH_DEFAULT,
  parameter int MAX_FETCH = brb_pkg::MAX_FETCH_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [brb_pkg::CMD_W-1:0]    in_cmd,
  input  wire logic                         in_first,
  input  wire logic [brb_pkg::AMOUNT_W-1:0] in_amount,
  input  wire logic [brb_pkg::BYTE_W-1:0]   in_byte,
  input  wire logic                         cfg_valid,
  input  wire logic [brb_pkg::CFG_W-1:0]    cfg_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output brb_pkg::res_t                     out_res,
  output logic                              mem_we,
  output logic      [$clog2(DEPTH)-1:0]     mem_waddr,
  output logic      [brb_pkg::BYTE_W-1:0]   mem_wdata,
  output logic                              mem_re,
  output logic      [$clog2(DEPTH)-1:0]     mem_raddr,
  input  wire logic [brb_pkg::BYTE_W-1:0]   mem_rdata
);

  localparam int PW = $clog2(DEPTH);
  localparam int SW = $clog2(DEPTH + 1);
  localparam int AW = brb_pkg::AMOUNT_W;
  localparam int CW = ((SW > AW) ? SW : AW) + 1;
  localparam int MW = $clog2(MAX_FETCH + 1);
  localparam int RS_RESET_INT =
    (brb_pkg::RING_SIZE_RESET > DEPTH) ? DEPTH : brb_pkg::RING_SIZE_RESET;
  localparam logic [SW-1:0] RS_RESET = SW'(RS_RESET_INT);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_FETCH = 1'b1;

  logic          state, state_next;
  logic [SW-1:0] ring_size, ring_size_next;
  logic [PW-1:0] rd_pos, rd_pos_next;
  logic [PW-1:0] wr_pos, wr_pos_next;
  logic [SW-1:0] fill, fill_next;
  logic          chunk_open, chunk_open_next;
  logic [AW-1:0] chunk_rem, chunk_rem_next;
  logic [MW-1:0] fcnt, fcnt_next;
  logic [PW-1:0] fpos, fpos_next;
  logic          out_valid_next;

  logic          load_ok, accept, load, write;
  brb_pkg::res_t load_res;
  logic [CW-1:0] fill_ext, amt_ext, rs_ext, cfg_ext;
  logic [CW-1:0] mark_k, rd_sum, rd_adv, nf;
  logic          fits;

  function automatic logic [PW-1:0] inc_pos(input logic [PW-1:0] pos,
                                            input logic [SW-1:0] rs);
    logic [SW-1:0] p;
    p = SW'(pos) + SW'(1);
    inc_pos = (p >= rs) ? '0 : p[PW-1:0];
  endfunction

  assign load_ok  = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE) && load_ok;
  assign accept   = in_valid && in_ready;

  assign fill_ext = CW'(fill);
  assign amt_ext  = CW'(in_amount);
  assign rs_ext   = CW'(ring_size);
  assign cfg_ext  = CW'(cfg_data);
  assign fits     = (fill_ext + amt_ext) < rs_ext;

  assign mark_k = (amt_ext < fill_ext) ? amt_ext : fill_ext;
  assign rd_sum = CW'(rd_pos) + mark_k;
  assign rd_adv = (rd_sum >= rs_ext) ? rd_sum - rs_ext : rd_sum;

  always_comb begin
    nf = (amt_ext < fill_ext) ? amt_ext : fill_ext;
    if (nf > CW'(MAX_FETCH)) begin
      nf = CW'(MAX_FETCH);
    end
  end

  always_comb begin
    state_next      = state;
    ring_size_next  = ring_size;
    rd_pos_next     = rd_pos;
    wr_pos_next     = wr_pos;
    fill_next       = fill;
    chunk_open_next = chunk_open;
    chunk_rem_next  = chunk_rem;
    fcnt_next       = fcnt;
    fpos_next       = fpos;
    write           = 1'b0;
    mem_re          = 1'b0;
    mem_raddr       = fpos;
    load            = 1'b0;
    load_res        = '0;
    load_res.last   = 1'b1;

    if (accept) begin
      unique case (in_cmd)
        brb_pkg::CMD_INSERT: begin
          if (in_first) begin
            chunk_open_next = 1'b0;
            chunk_rem_next  = '0;
            if (fits) begin
              load_res.accepted = 1'b1;
              if (in_amount != '0) begin
                write           = 1'b1;
                chunk_rem_next  = in_amount - AW'(1);
                chunk_open_next = (in_amount != AW'(1));
              end
            end
          end else if (chunk_open && chunk_rem != '0) begin
            load_res.accepted = 1'b1;
            write             = 1'b1;
            chunk_rem_next    = chunk_rem - AW'(1);
            chunk_open_next   = (chunk_rem != AW'(1));
          end
          if (write) begin
            wr_pos_next = inc_pos(wr_pos, ring_size);
            fill_next   = fill + SW'(1);
          end
          load = 1'b1;
        end
        brb_pkg::CMD_FETCH: begin
          if (nf == '0) begin
            load = 1'b1;
          end else begin
            mem_re     = 1'b1;
            mem_raddr  = rd_pos;
            fpos_next  = inc_pos(rd_pos, ring_size);
            fcnt_next  = MW'(nf);
            state_next = ST_FETCH;
          end
        end
        brb_pkg::CMD_MARK: begin
          rd_pos_next = rd_adv[PW-1:0];
          fill_next   = fill - SW'(mark_k);
          load        = 1'b1;
        end
        brb_pkg::CMD_QUERY: begin
          load_res.accepted = fits;
          load              = 1'b1;
        end
        default: begin
          load = 1'b1;
        end
      endcase
    end else if (state == ST_FETCH && load_ok) begin
      // read data for the current byte sits in the store's output register
      load                = 1'b1;
      load_res.data_valid = 1'b1;
      load_res.data_byte  = mem_rdata;
      load_res.last       = (fcnt == MW'(1));
      fcnt_next           = fcnt - MW'(1);
      if (fcnt == MW'(1)) begin
        state_next = ST_IDLE;
      end else begin
        mem_re    = 1'b1;
        mem_raddr = fpos;
        fpos_next = inc_pos(fpos, ring_size);
      end
    end

    load_res.fill_count = brb_pkg::FILL_W'(fill_next);

    // size write empties the ring; user must issue it only when idle, unchecked
    if (cfg_valid) begin
      if (cfg_ext < CW'(2)) begin
        ring_size_next = SW'(2);
      end else if (cfg_ext > CW'(DEPTH)) begin
        ring_size_next = SW'(DEPTH);
      end else begin
        ring_size_next = SW'(cfg_ext);
      end
      rd_pos_next     = '0;
      wr_pos_next     = '0;
      fill_next       = '0;
      chunk_open_next = 1'b0;
      chunk_rem_next  = '0;
    end
  end

  assign mem_we    = write;
  assign mem_waddr = wr_pos;
  assign mem_wdata = in_byte;

  always_comb begin
    if (load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      ring_size  <= RS_RESET;
      rd_pos     <= '0;
      wr_pos     <= '0;
      fill       <= '0;
      chunk_open <= 1'b0;
      chunk_rem  <= '0;
      fcnt       <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      ring_size  <= ring_size_next;
      rd_pos     <= rd_pos_next;
      wr_pos     <= wr_pos_next;
      fill       <= fill_next;
      chunk_open <= chunk_open_next;
      chunk_rem  <= chunk_rem_next;
      fcnt       <= fcnt_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    fpos <= fpos_next;
    if (load) begin
      out_res <= load_res;
    end
  end

  a_fill_below_size: assert property (@(posedge clk) disable iff (rst)
    fill < ring_size)
    else $error("fill reached ring size");

  a_pos_in_ring: assert property (@(posedge clk) disable iff (rst)
    (SW'(rd_pos) < ring_size) && (SW'(wr_pos) < ring_size))
    else $error("position outside ring");

  a_fetch_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FETCH) |-> (fcnt != '0))
    else $error("fetch run with no bytes left");

  a_chunk_open_rem: assert property (@(posedge clk) disable iff (rst)
    chunk_open |-> (chunk_rem != '0))
    else $error("open chunk with nothing remaining");

  a_write_only_idle: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_IDLE))
    else $error("store written during fetch run");

endmodule

`default_nettype wire

// ----- rtl/byte_ring_buffer_peek_commit_top.sv -----
// Insert, mark-read and space query results are registered in the cycle after
// the input transaction; a fetch's first byte passes the store read register
// and result register, then one byte per cycle while m_axis_tready is high.
// Throughput: one non-fetch item per cycle while m_axis_tready is high; a
// fetch holds the input to its end (one store read port, one byte per read).
// Reset: synchronous, empties the ring; the byte store itself is not cleared.
// ----------------------------------------------------------------------------
// byte_ring_buffer_peek_commit_top
// Byte ring buffer with chunk admission, peek fetch and mark-read commit.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_ring_buffer_peek_commit_top #(
  parameter int DEPTH     = brb_pkg::DEPTH_DEFAULT,
  parameter int MAX_FETCH = brb_pkg::MAX_FETCH_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // amount [12:0], data_byte [20:13]
  input  wire logic [brb_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // cmd [1:0], first_of_chunk [2]
  input  wire logic [brb_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // data_byte_res [7:0], fill_count [19:8]
  output logic      [brb_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // accepted [0], data_valid [1]
  output logic      [brb_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
  output logic                                 m_axis_tlast,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [brb_pkg::CFG_W-1:0]       cfg_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int AW = brb_pkg::AMOUNT_W;
  localparam int BW = brb_pkg::BYTE_W;
  localparam int FW = brb_pkg::FILL_W;

  logic          mem_we, mem_re;
  logic [PW-1:0] mem_waddr, mem_raddr;
  logic [BW-1:0] mem_wdata, mem_rdata;
  brb_pkg::res_t res;

  assign cfg_ready = 1'b1;

  brb_ctrl #(
    .DEPTH     (DEPTH),
    .MAX_FETCH (MAX_FETCH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_cmd    (s_axis_tuser[brb_pkg::CMD_W-1:0]),
    .in_first  (s_axis_tuser[brb_pkg::CMD_W]),
    .in_amount (s_axis_tdata[AW-1:0]),
    .in_byte   (s_axis_tdata[AW+BW-1:AW]),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  brb_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign m_axis_tdata = {{(brb_pkg::OUT_TDATA_W - FW - BW){1'b0}},
                         res.fill_count, res.data_byte};
  assign m_axis_tuser = {res.data_valid, res.accepted};
  assign m_axis_tlast = res.last;

endmodule

`default_nettype wire
